// ===== hw/rtl/bfh_pkg.sv =====
// bfh_pkg: shared constants, command codes and stack operation codes for the
// back/forward history block. No dependencies.
package bfh_pkg;

  // Default sizing
  localparam int unsigned BFH_STACK_DEPTH = 16;
  localparam int unsigned BFH_PAGE_BITS   = 16;
  localparam int unsigned BFH_CMD_W       = 2;

  // Command codes carried on the request channel; code 3 is unused
  typedef enum logic [BFH_CMD_W-1:0] {
    CMD_VISIT   = 2'd0,
    CMD_BACK    = 2'd1,
    CMD_FORWARD = 2'd2
  } bfh_cmd_e;

  // Operation applied to every cell of a stack together
  typedef enum logic [1:0] {
    STK_HOLD  = 2'd0,
    STK_PUSH  = 2'd1,
    STK_POP   = 2'd2,
    STK_CLEAR = 2'd3
  } bfh_stack_op_e;

endpackage

// ===== hw/rtl/bfh_req_if.sv =====
// bfh_req_if: request channel (command and page id) with valid/ready.
// Depends on bfh_pkg.
interface bfh_req_if
  import bfh_pkg::*;
#(
  parameter int unsigned PAGE_BITS = BFH_PAGE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [BFH_CMD_W-1:0] cmd;
  logic [PAGE_BITS-1:0] page_id;

  modport source (output valid, output cmd, output page_id, input ready);
  modport sink   (input valid, input cmd, input page_id, output ready);
endinterface

// ===== hw/rtl/bfh_rsp_if.sv =====
// bfh_rsp_if: result channel (current page, flags, stack depths) with
// valid/ready. Depends on bfh_pkg.
interface bfh_rsp_if
  import bfh_pkg::*;
#(
  parameter int unsigned PAGE_BITS = BFH_PAGE_BITS,
  parameter int unsigned CNT_W     = $clog2(BFH_STACK_DEPTH + 1)
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] current_page;
  logic                 page_valid;
  logic                 moved;
  logic [CNT_W-1:0]     back_depth;
  logic [CNT_W-1:0]     forward_depth;

  modport source (output valid, output current_page, output page_valid, output moved,
                  output back_depth, output forward_depth, input ready);
  modport sink   (input valid, input current_page, input page_valid, input moved,
                  input back_depth, input forward_depth, output ready);
endinterface

// ===== hw/rtl/bfh_cell.sv =====
// bfh_cell: one stack entry. Takes its neighbour's value on a push or pop.
// Depends on bfh_pkg.
module bfh_cell
  import bfh_pkg::*;
#(
  parameter int unsigned PAGE_BITS = BFH_PAGE_BITS
) (
  input  logic                 clk_i,
  input  bfh_stack_op_e        op_i,
  input  logic [PAGE_BITS-1:0] above_i,  // neighbour nearer the top, or push data
  input  logic [PAGE_BITS-1:0] below_i,  // neighbour deeper down
  output logic [PAGE_BITS-1:0] data_o
);

  logic [PAGE_BITS-1:0] data_q, data_d;

  // shift towards the bottom on push, towards the top on pop
  always_comb begin
    data_d = data_q;
    unique case (op_i)
      STK_PUSH: data_d = above_i;
      STK_POP:  data_d = below_i;
      default:  data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/bfh_stack.sv =====
// bfh_stack: a chain of bfh_cell entries with the top in cell 0 and a fill
// count. A push onto a full stack drops the bottom entry. Depends on bfh_pkg.
module bfh_stack
  import bfh_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = BFH_STACK_DEPTH,
  parameter int unsigned PAGE_BITS   = BFH_PAGE_BITS,
  parameter int unsigned CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfh_stack_op_e        op_i,
  input  logic [PAGE_BITS-1:0] push_data_i,
  output logic [PAGE_BITS-1:0] top_o,
  output logic                 empty_o,
  output logic [CNT_W-1:0]     count_o
);

  logic [PAGE_BITS-1:0] cell_data [STACK_DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;

  // cell chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [PAGE_BITS-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = push_data_i;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_data[i];
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    bfh_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op_i),
      .above_i(above),
      .below_i(below),
      .data_o (cell_data[i])
    );
  end

  // fill count, saturating at the depth
  always_comb begin
    count_d = count_q;
    unique case (op_i)
      STK_PUSH:  if (count_q != CNT_W'(STACK_DEPTH)) count_d = count_q + 1'b1;
      STK_POP:   count_d = count_q - 1'b1;
      STK_CLEAR: count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = cell_data[0];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== hw/rtl/back_forward_history_stacks_core.sv =====
// Back/forward page history: current page plus back and forward stacks.
// Depends on bfh_pkg, bfh_req_if, bfh_rsp_if and bfh_stack.
//
// Usage:
//   req_i carries one command (visit, back, forward) with a page id; a
//   transfer happens when valid and ready are both high. Every command gives
//   exactly one result on rsp_o: current page, page-valid flag, whether the
//   page moved, and both stack depths after the command.
//   The result is registered and shows on rsp_o in the cycle after the
//   request transfer. Throughput is one command per cycle while rsp_o is
//   not stalled; a push or pop shifts every cell of its chain by one place
//   and steps its fill count in the same cycle.
//   A visit with no current page pushes nothing; back and forward with an
//   empty source stack leave the state alone and report moved = 0, as does
//   the unused command code. A push onto a full back stack drops the oldest.
//   While a result waits with rsp_o.ready low, req_i.ready is low and the
//   state holds; a new request is taken in the same cycle the pending
//   result is transferred.
//   Reset clears the counts, the current page and the output valid; stack
//   entries are not cleared and are never read before being written.
module back_forward_history_stacks_core
  import bfh_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = BFH_STACK_DEPTH,
  parameter int unsigned PAGE_BITS   = BFH_PAGE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfh_req_if.sink   req_i,
  bfh_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic                 accept;
  logic                 rsp_valid_q, rsp_valid_d;
  logic                 moved_q, moved_d;
  logic [PAGE_BITS-1:0] present_q, present_d;
  logic                 present_valid_q, present_valid_d;

  bfh_stack_op_e        back_op, fwd_op;
  logic [PAGE_BITS-1:0] back_top, fwd_top;
  logic                 back_empty, fwd_empty;
  logic [CNT_W-1:0]     back_cnt, fwd_cnt;

  // take a request whenever the result slot is free or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // command decode
  always_comb begin
    back_op         = STK_HOLD;
    fwd_op          = STK_HOLD;
    present_d       = present_q;
    present_valid_d = present_valid_q;
    moved_d         = moved_q;
    if (accept) begin
      moved_d = 1'b0;
      unique case (req_i.cmd)
        CMD_VISIT: begin
          if (present_valid_q) back_op = STK_PUSH;
          fwd_op          = STK_CLEAR;
          present_d       = req_i.page_id;
          present_valid_d = 1'b1;
          moved_d         = 1'b1;
        end
        CMD_BACK: begin
          if (!back_empty) begin
            back_op   = STK_POP;
            fwd_op    = STK_PUSH;
            present_d = back_top;
            moved_d   = 1'b1;
          end
        end
        CMD_FORWARD: begin
          if (!fwd_empty) begin
            fwd_op    = STK_POP;
            back_op   = STK_PUSH;
            present_d = fwd_top;
            moved_d   = 1'b1;
          end
        end
        default: moved_d = 1'b0;
      endcase
    end
  end

  // output valid: set by a request, cleared once the result transfers
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q     <= 1'b0;
      moved_q         <= 1'b0;
      present_q       <= '0;
      present_valid_q <= 1'b0;
    end else begin
      rsp_valid_q     <= rsp_valid_d;
      moved_q         <= moved_d;
      present_q       <= present_d;
      present_valid_q <= present_valid_d;
    end
  end

  bfh_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .PAGE_BITS  (PAGE_BITS),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (back_op),
    .push_data_i(present_q),
    .top_o      (back_top),
    .empty_o    (back_empty),
    .count_o    (back_cnt)
  );

  bfh_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .PAGE_BITS  (PAGE_BITS),
    .CNT_W      (CNT_W)
  ) u_fwd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (fwd_op),
    .push_data_i(present_q),
    .top_o      (fwd_top),
    .empty_o    (fwd_empty),
    .count_o    (fwd_cnt)
  );

  // state only changes on a request transfer, so it doubles as the result
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.current_page  = present_q;
  assign rsp_o.page_valid    = present_valid_q;
  assign rsp_o.moved         = moved_q;
  assign rsp_o.back_depth    = back_cnt;
  assign rsp_o.forward_depth = fwd_cnt;

endmodule

// ===== hw/rtl/bfh_checker.sv =====
// bfh_checker: port-level assertions for the history block, bound to
// back_forward_history_stacks_core. Depends on bfh_pkg.
module bfh_checker
  import bfh_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = BFH_STACK_DEPTH,
  parameter int unsigned PAGE_BITS   = BFH_PAGE_BITS,
  parameter int unsigned CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic [BFH_CMD_W-1:0] req_cmd_i,
  input logic [PAGE_BITS-1:0] req_page_id_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [PAGE_BITS-1:0] rsp_current_page_i,
  input logic                 rsp_page_valid_i,
  input logic                 rsp_moved_i,
  input logic [CNT_W-1:0]     rsp_back_depth_i,
  input logic [CNT_W-1:0]     rsp_forward_depth_i
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_current_page_i)
      && $stable(rsp_back_depth_i) && $stable(rsp_forward_depth_i))
    else $error("result changed while stalled");

  // the two stacks together never hold more than one stack's worth
  a_depth_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ({1'b0, rsp_back_depth_i} + {1'b0, rsp_forward_depth_i})
      <= (CNT_W + 1)'(STACK_DEPTH))
    else $error("stack depths exceed capacity");

  // no page yet means empty history
  a_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_page_valid_i |-> rsp_current_page_i == '0
      && rsp_back_depth_i == '0 && rsp_forward_depth_i == '0 && !rsp_moved_i)
    else $error("history present without a page");

  // a visit lands the page and empties the forward stack
  a_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == CMD_VISIT |=> rsp_valid_i
      && rsp_moved_i && rsp_page_valid_i && rsp_forward_depth_i == '0
      && rsp_current_page_i == $past(req_page_id_i))
    else $error("visit result wrong");

endmodule

bind back_forward_history_stacks_core bfh_checker #(
  .STACK_DEPTH(STACK_DEPTH),
  .PAGE_BITS  (PAGE_BITS)
) u_bfh_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_cmd_i          (req_i.cmd),
  .req_page_id_i      (req_i.page_id),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_current_page_i (rsp_o.current_page),
  .rsp_page_valid_i   (rsp_o.page_valid),
  .rsp_moved_i        (rsp_o.moved),
  .rsp_back_depth_i   (rsp_o.back_depth),
  .rsp_forward_depth_i(rsp_o.forward_depth)
);
